FILE: hw/rtl/part_request_scheduler_assert.svh
// assertion macros for the part request scheduler
`ifndef PART_REQUEST_SCHEDULER_ASSERT_SVH
`define PART_REQUEST_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PRS_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("prs check failed");
`define PRS_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("prs check failed");
`else
`define PRS_ASSERT_IMP(label, a, b)
`define PRS_ASSERT_NXT(label, a, b)
`endif
`endif

FILE: hw/rtl/prs_pkg.sv
// shared types and constants for the part request scheduler
package prs_pkg;

    localparam int DEF_MAX_PARTS = 1024;
    localparam int DEF_TIME_BITS = 48;

    localparam int PART_COUNT_W = 11;
    localparam int TIMEOUT_W    = 32;
    localparam int IDX_FIELD_W  = 10;
    localparam int NOW_FIELD_W  = 48;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd10000;

    localparam logic OP_MARK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic REG_PART_COUNT = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } scan_ctrl_t;

    typedef struct packed {
        logic any_miss;
        logic due_hit;
    } scan_flags_t;

endpackage

FILE: hw/rtl/prs_mem.sv
// single port memory with registered read data
module prs_mem
    import prs_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_PARTS,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/prs_scan.sv
// shared scan unit: tests one entry a cycle and keeps the first hits
module prs_scan
    import prs_pkg::*;
#(
    parameter int IDX_W     = 10,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scan_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]     entry_idx,
    input  logic                 entry_rcv,
    input  logic [TIME_BITS-1:0] entry_deadline,
    input  logic [TIME_BITS-1:0] now,
    output scan_flags_t          flags,
    output logic [IDX_W-1:0]     first_miss,
    output logic [IDX_W-1:0]     first_due
);

    scan_flags_t      flags_reg;
    scan_flags_t      flags_next;
    logic [IDX_W-1:0] first_miss_reg;
    logic [IDX_W-1:0] first_miss_next;
    logic [IDX_W-1:0] first_due_reg;
    logic [IDX_W-1:0] first_due_next;
    logic             miss;
    logic             due;

    // missing entry, and missing with its deadline strictly past
    assign miss = !entry_rcv;
    assign due  = miss && (entry_deadline < now);

    always_comb
    begin
        flags_next      = flags_reg;
        first_miss_next = first_miss_reg;
        first_due_next  = first_due_reg;
        if (ctrl.clear)
        begin
            flags_next = '0;
        end
        else if (ctrl.valid)
        begin
            if (miss && !flags_reg.any_miss)
            begin
                flags_next.any_miss = 1'b1;
                first_miss_next     = entry_idx;
            end
            if (due && !flags_reg.due_hit)
            begin
                flags_next.due_hit = 1'b1;
                first_due_next     = entry_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_miss_reg <= first_miss_next;
        first_due_reg  <= first_due_next;
    end

    assign flags      = flags_reg;
    assign first_miss = first_miss_reg;
    assign first_due  = first_due_reg;

endmodule

FILE: hw/rtl/part_request_scheduler.sv
// top level of the part request scheduler: sequencer, registers and stores
// Part request scheduler. Keeps a received bit and a retry deadline for each
// part of a download. A mark item (tuser 0) records a received part and flags
// an index at or beyond the live part count; a request item (tuser 1) picks
// the lowest missing part whose deadline lies strictly before now_ms, else
// the lowest missing part, and moves its deadline to now plus timeout_ms.
// Every item returns one result item that also says whether all live parts
// have arrived. Sequence: after reset the block sweeps all MAX_PARTS entries of
// both stores to zero with s_tready low (config writes still land). An item
// then goes through accept, one pass of the single scan unit over the n live
// entries (n being part_count capped at MAX_PARTS), one entry per cycle
// through the memory read port, then drain, update and output.
// With no live part the scan and drain are skipped.
// The result sits in an output register, and the next item is taken once the
// result has been loaded there, even if it has not yet been taken.
`include "part_request_scheduler_assert.svh"
module part_request_scheduler
    import prs_pkg::*;
#(
    parameter int MAX_PARTS = DEF_MAX_PARTS,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input items
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,   // part_index[9:0], now_ms[57:10], zero pad
    input  logic [0:0]              s_tuser,   // opcode
    // result items
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,   // chosen_part, part_found, all_received,
                                               // bad_index, zero pad
    // configuration writes
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [TIMEOUT_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_PARTS);
    localparam int CNT_W = $clog2(MAX_PARTS + 1);

    // configuration registers
    logic [PART_COUNT_W-1:0] part_count_reg;
    logic [TIMEOUT_W-1:0]    timeout_reg;

    // sequencer
    state_t                  state_reg;
    state_t                  state_next;
    logic [IDX_W-1:0]        scan_cnt_reg;
    logic [IDX_W-1:0]        scan_cnt_next;

    // latched item
    logic                    op_reg;
    logic                    bad_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [CNT_W-1:0]        n_reg;

    // read pipeline tag
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;

    // output register
    logic                    m_tvalid_reg;
    logic [IDX_FIELD_W-1:0]  out_chosen_reg;
    logic                    out_found_reg;
    logic                    out_all_reg;
    logic                    out_bad_reg;

    // input unpacking
    logic [IDX_FIELD_W-1:0]  in_idx;
    logic [NOW_FIELD_W-1:0]  in_now;
    logic                    in_op;
    logic [31:0]             in_idx32;
    logic [63:0]             now64;
    logic [63:0]             tmo64;
    logic [31:0]             live_n32;
    logic                    bad_in;
    logic                    accept;
    logic                    out_free;
    logic                    clear_last;
    logic                    scan_last;

    // memory ports
    logic                    map_we;
    logic [IDX_W-1:0]        map_addr;
    logic                    map_wdata;
    logic                    map_rdata;
    logic                    dl_we;
    logic [IDX_W-1:0]        dl_addr;
    logic [TIME_BITS-1:0]    dl_wdata;
    logic [TIME_BITS-1:0]    dl_rdata;

    // scan unit
    scan_ctrl_t              scan_ctrl;
    scan_flags_t             scan_flags;
    logic [IDX_W-1:0]        first_miss;
    logic [IDX_W-1:0]        first_due;
    logic [IDX_W-1:0]        chosen_idx;
    logic [31:0]             chosen32;
    logic                    found;
    logic [TIME_BITS-1:0]    new_deadline;

    assign in_idx   = s_tdata[IDX_FIELD_W-1:0];
    assign in_now   = s_tdata[IDX_FIELD_W+NOW_FIELD_W-1:IDX_FIELD_W];
    assign in_op    = s_tuser[0];
    assign in_idx32 = 32'(in_idx);
    assign now64    = 64'(in_now);
    assign tmo64    = 64'(timeout_reg);

    // part_count above capacity acts as capacity
    assign live_n32 = (32'(part_count_reg) > 32'(MAX_PARTS)) ? 32'(MAX_PARTS)
                                                              : 32'(part_count_reg);
    assign bad_in   = in_idx32 >= live_n32;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign clear_last = (32'(scan_cnt_reg) == 32'(MAX_PARTS) - 32'd1);
    assign scan_last  = (32'(scan_cnt_reg) == 32'(n_reg) - 32'd1);

    // request picks a due part first, else any missing part
    assign chosen_idx   = scan_flags.due_hit ? first_due : first_miss;
    assign chosen32     = 32'(chosen_idx);
    assign found        = (op_reg == OP_REQUEST) && scan_flags.any_miss;
    assign new_deadline = now_reg + tmo64[TIME_BITS-1:0];

    // configuration writes, taken in any state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= '0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PART_COUNT: part_count_reg <= cfg_wdata[PART_COUNT_W-1:0];
                REG_TIMEOUT:    timeout_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    // no live parts: nothing to scan
                    state_next = (live_n32 == 32'd0) ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: state_next = S_UPDATE;
            S_UPDATE:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_CLEAR;
        endcase
    end

    // sequencer outputs: counter and memory ports
    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        map_we        = 1'b0;
        map_addr      = scan_cnt_reg;
        map_wdata     = 1'b0;
        dl_we         = 1'b0;
        dl_addr       = scan_cnt_reg;
        dl_wdata      = '0;
        case (state_reg)
            S_CLEAR:
            begin
                // zero one entry of both stores per cycle
                map_we        = 1'b1;
                dl_we         = 1'b1;
                scan_cnt_next = clear_last ? '0 : scan_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                scan_cnt_next = '0;
                // mark lands before the scan reads the map
                if (accept && (in_op == OP_MARK) && !bad_in)
                begin
                    map_we    = 1'b1;
                    map_addr  = in_idx32[IDX_W-1:0];
                    map_wdata = 1'b1;
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            S_UPDATE:
            begin
                if (found)
                begin
                    dl_we    = 1'b1;
                    dl_addr  = chosen_idx;
                    dl_wdata = new_deadline;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_vld_reg   <= (state_reg == S_SCAN);
            if ((state_reg == S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_cnt_reg;
        if (accept)
        begin
            op_reg  <= in_op;
            bad_reg <= (in_op == OP_MARK) && bad_in;
            now_reg <= now64[TIME_BITS-1:0];
            n_reg   <= live_n32[CNT_W-1:0];
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_chosen_reg <= found ? chosen32[IDX_FIELD_W-1:0] : '0;
            out_found_reg  <= found;
            out_all_reg    <= !scan_flags.any_miss;
            out_bad_reg    <= bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_bad_reg, out_all_reg, out_found_reg, out_chosen_reg};

    // received map and deadline table
    prs_mem #(
        .DEPTH (MAX_PARTS),
        .WIDTH (1)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    prs_mem #(
        .DEPTH (MAX_PARTS),
        .WIDTH (TIME_BITS)
    ) u_deadline (
        .clk   (clk),
        .we    (dl_we),
        .addr  (dl_addr),
        .wdata (dl_wdata),
        .rdata (dl_rdata)
    );

    // scan is restarted on every accepted item
    assign scan_ctrl.clear = accept;
    assign scan_ctrl.valid = rd_vld_reg;

    prs_scan #(
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (scan_ctrl),
        .entry_idx      (rd_idx_reg),
        .entry_rcv      (map_rdata),
        .entry_deadline (dl_rdata),
        .now            (now_reg),
        .flags          (scan_flags),
        .first_miss     (first_miss),
        .first_due      (first_due)
    );

    // a found part means not everything has arrived
    `PRS_ASSERT_IMP(a_found_not_all, m_tvalid && m_tdata[10], !m_tdata[11])
    // a bad mark never reports a chosen part
    `PRS_ASSERT_IMP(a_bad_not_found, m_tvalid && m_tdata[12], !m_tdata[10])
    // a chosen part lies below the live count
    `PRS_ASSERT_IMP(a_chosen_live, (state_reg == S_UPDATE) && found,
                    32'(chosen_idx) < 32'(n_reg))
    // one item at a time: ready drops right after an accept
    `PRS_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

FILE: sim/tb_part_request_scheduler.sv
// self-checking testbench for the part request scheduler
module tb_part_request_scheduler
    import prs_pkg::*;
();

    localparam int CAPACITY    = DEF_MAX_PARTS;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 1100;
    localparam int LONG_HOLD   = 700;

    // tracks the received map and retry deadlines, and holds the results still due
    class part_scoreboard;
        typedef struct {
            logic [IDX_FIELD_W-1:0] chosen;
            logic                   found;
            logic                   all_in;
            logic                   bad;
        } pick_t;

        bit                     got [CAPACITY];
        logic [NOW_FIELD_W-1:0] due_at [CAPACITY];
        logic [PART_COUNT_W-1:0] part_count;
        logic [TIMEOUT_W-1:0]   timeout_ms;
        pick_t                  due_results [$];
        int unsigned            errors;
        logic [IDX_FIELD_W-1:0] last_pick;
        bit                     have_pick;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                got[i] = 1'b0;
                due_at[i] = '0;
            end
            part_count = '0;
            timeout_ms = TIMEOUT_RESET;
            errors = 0;
            last_pick = '0;
            have_pick = 1'b0;
        endfunction

        function void set_reg(logic idx, logic [TIMEOUT_W-1:0] val);
            if (idx == REG_PART_COUNT)
                part_count = val[PART_COUNT_W-1:0];
            else
                timeout_ms = val;
        endfunction

        function int unsigned live_parts();
            return (part_count > CAPACITY) ? CAPACITY : part_count;
        endfunction

        // apply one accepted item and queue the result it must produce
        function void accept_item(logic op, logic [IDX_FIELD_W-1:0] idx,
                                  logic [NOW_FIELD_W-1:0] now);
            pick_t       r;
            int unsigned n;
            bit          hit;
            n = live_parts();
            hit = 1'b0;
            r.chosen = '0;
            r.found = 1'b0;
            r.bad = 1'b0;
            if (op == OP_MARK)
            begin
                if (idx >= n)
                    r.bad = 1'b1;
                else
                    got[idx] = 1'b1;
            end
            else
            begin
                // lowest missing part that is overdue, else lowest missing part
                for (int i = 0; i < n && !hit; i++)
                    if (!got[i] && due_at[i] < now)
                    begin
                        r.chosen = i[IDX_FIELD_W-1:0];
                        hit = 1'b1;
                    end
                for (int i = 0; i < n && !hit; i++)
                    if (!got[i])
                    begin
                        r.chosen = i[IDX_FIELD_W-1:0];
                        hit = 1'b1;
                    end
                if (hit)
                begin
                    due_at[r.chosen] = now + {{(NOW_FIELD_W-TIMEOUT_W){1'b0}}, timeout_ms};
                    r.found = 1'b1;
                    last_pick = r.chosen;
                end
                have_pick = hit;
            end
            r.all_in = 1'b1;
            for (int i = 0; i < n; i++)
                if (!got[i])
                    r.all_in = 1'b0;
            due_results.push_back(r);
        endfunction

        task report(string what);
            if (errors < 50)
                $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            pick_t r;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %h with nothing pending", d));
                return;
            end
            r = due_results.pop_front();
            if (d[9:0] !== r.chosen)
                report($sformatf("chosen_part %0d, want %0d", d[9:0], r.chosen));
            if (d[10] !== r.found)
                report($sformatf("part_found %b, want %b", d[10], r.found));
            if (d[11] !== r.all_in)
                report($sformatf("all_received %b, want %b", d[11], r.all_in));
            if (d[12] !== r.bad)
                report($sformatf("bad_index %b, want %b", d[12], r.bad));
            if (d[15:13] !== 3'b000)
                report($sformatf("pad bits %b not zero", d[15:13]));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [TIMEOUT_W-1:0]  cfg_wdata;

    part_scoreboard sb;
    bit             tx_idle_on;
    bit             rx_idle_on;
    bit             hold_req;
    int unsigned    hold_left;
    int unsigned    cycle_count;

    part_request_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: checks every accepted result, stalls in bursts or on request
    initial
    begin
        m_tready <= 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [NOW_FIELD_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[NOW_FIELD_W-1:0];
    endfunction

    // offer one item and hold it until taken; tvalid stays high unless a gap follows
    task automatic send_item(logic op, logic [IDX_FIELD_W-1:0] idx,
                             logic [NOW_FIELD_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W-NOW_FIELD_W-IDX_FIELD_W){1'b0}}, now, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.accept_item(op, idx, now);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    // stop offering and wait until every pending result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [TIMEOUT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // one download: mostly requests and marks of the parts just picked,
    // with some stray marks and random noise
    task automatic run_download(int unsigned count, logic [TIMEOUT_W-1:0] tmo,
                                int unsigned items, logic [NOW_FIELD_W-1:0] base,
                                int unsigned max_step);
        logic [NOW_FIELD_W-1:0] t;
        int unsigned            k;
        int unsigned            top;
        write_reg(REG_PART_COUNT, count);
        write_reg(REG_TIMEOUT, tmo);
        t = base;
        top = (count > CAPACITY - 1) ? CAPACITY - 1 : count;
        repeat (items)
        begin
            k = $urandom_range(0, 99);
            if (k < 50)
            begin
                t = t + 48'($urandom_range(0, max_step));
                send_item(OP_REQUEST, 10'($urandom_range(0, CAPACITY - 1)), t);
            end
            else if (k < 80 && sb.have_pick)
                send_item(OP_MARK, sb.last_pick, rand_time());
            else if (k < 90)
                send_item(OP_MARK, 10'($urandom_range(0, top)), rand_time());
            else
                send_item(1'($urandom_range(0, 1)), 10'($urandom_range(0, CAPACITY - 1)),
                          rand_time());
        end
        drain();
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return $urandom_range(1, 50);
            2: return $urandom;
            default: return '1;
        endcase
    endfunction

    initial
    begin
        sb = new();
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_MARK;
        cfg_we    = 1'b0;
        cfg_index = REG_PART_COUNT;
        cfg_wdata = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req = 1'b0;
        cycle_count = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero parts: nothing to fetch, everything counts as received
        send_item(OP_REQUEST, '0, '0);
        send_item(OP_MARK, '0, '0);
        send_item(OP_MARK, '1, '1);
        drain();

        // three parts: first-pass pick, overdue pick, repeated and bad marks
        write_reg(REG_PART_COUNT, 3);
        send_item(OP_REQUEST, '1, 48'd0);
        send_item(OP_REQUEST, '0, 48'd5);
        send_item(OP_REQUEST, '0, 48'd20000);
        send_item(OP_MARK, 10'd1, '0);
        send_item(OP_MARK, 10'd1, '0);
        send_item(OP_MARK, 10'd3, '0);
        send_item(OP_MARK, 10'd0, '0);
        send_item(OP_REQUEST, '0, 48'd30000);
        send_item(OP_MARK, 10'd2, '0);
        send_item(OP_REQUEST, '0, 48'd40000);
        drain();

        // count beyond capacity, longest timeout and wrapping deadlines
        write_reg(REG_PART_COUNT, 2047);
        write_reg(REG_TIMEOUT, '1);
        send_item(OP_REQUEST, '0, '1);
        send_item(OP_REQUEST, '0, '1);
        send_item(OP_MARK, 10'd1023, '0);
        send_item(OP_REQUEST, '0, 48'd1);
        drain();

        // shrunk count keeps old entries, then full capacity again
        write_reg(REG_PART_COUNT, 1);
        send_item(OP_REQUEST, '0, 48'd2);
        send_item(OP_MARK, 10'd1, '0);
        drain();
        write_reg(REG_PART_COUNT, 1024);
        write_reg(REG_TIMEOUT, '0);
        send_item(OP_MARK, 10'd1023, '0);
        send_item(OP_REQUEST, '0, 48'd7);
        send_item(OP_REQUEST, '0, 48'd7);
        drain();

        run_download(8, '0, 40, rand_time(), 20);

        // long result stall while items keep coming, so the input backs up
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        run_download(33, 32'd5, 60, rand_time(), 3);
        tx_idle_on = 1'b1;

        run_download(1024, 32'd100, 15, rand_time(), 200);
        run_download(1, 32'd1, 20, rand_time(), 3);
        run_download(16, '1, 40, '1 - 48'd50, 30);
        run_download(5, 32'd10, 30, rand_time(), 20);
        run_download(20, 32'd10, 40, rand_time(), 20);
        run_download(2047, $urandom, 12, rand_time(), 32'hFFFF_FFFF);

        repeat (5)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            run_download($urandom_range(0, 48), pick_timeout(), 50, rand_time(),
                         ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 40);
        end

        // last stretch runs with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_download(24, 32'd15, 60, rand_time(), 10);

        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
